// ===== src/hbp_pkg.sv =====
// Shared types and constants for the histogram back-projection core.
// No dependencies; every other file of the block but hbp_checker imports this package.
`timescale 1ns / 1ps

package hbp_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // Widest combined index: z*by*bx + y*bx + x with 9-bit terms
    localparam int IDX_W       = 28;
    localparam int BIN_W       = 12;
    localparam int PROB_W      = 32;

    // Result queue sized to cover the lookup latency at full rate
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] REG_BINS_X        = 2'd0;
    localparam logic [1:0] REG_BINS_Y        = 2'd1;
    localparam logic [1:0] REG_BINS_Z        = 2'd2;
    localparam logic [1:0] REG_CHANNELS_USED = 2'd3;

    localparam logic [1:0] CH_TWO   = 2'd2;
    localparam logic [1:0] CH_THREE = 2'd3;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic [8:0] bins_x;
        logic [8:0] bins_y;
        logic [8:0] bins_z;
        logic [1:0] channels_used;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [11:0] entry_index;
        logic [31:0] entry_value;
        logic [7:0]  chan_first;
        logic [7:0]  chan_second;
        logic [7:0]  chan_third;
    } item_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [PROB_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic             oor;
        logic [BIN_W-1:0] bin;
    } look_tag_t;

    typedef struct packed {
        logic              oor;
        logic [BIN_W-1:0]  bin;
        logic [PROB_W-1:0] prob;
    } result_t;

endpackage

// ===== src/hbp_regs.sv =====
// APB configuration registers: bin counts per channel and channel count.
// Depends on hbp_pkg for the register codes and the cfg_t struct.
`timescale 1ns / 1ps

module hbp_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output hbp_pkg::cfg_t cfg
);
    import hbp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_hit) begin
            unique case (paddr[3:2])
                REG_BINS_X:        cfg_next.bins_x        = pwdata[8:0];
                REG_BINS_Y:        cfg_next.bins_y        = pwdata[8:0];
                REG_BINS_Z:        cfg_next.bins_z        = pwdata[8:0];
                REG_CHANNELS_USED: cfg_next.channels_used = pwdata[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BINS_X:        prdata = {23'd0, cfg_reg.bins_x};
            REG_BINS_Y:        prdata = {23'd0, cfg_reg.bins_y};
            REG_BINS_Z:        prdata = {23'd0, cfg_reg.bins_z};
            REG_CHANNELS_USED: prdata = {30'd0, cfg_reg.channels_used};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bins_x        <= 9'd16;
            cfg_reg.bins_y        <= 9'd16;
            cfg_reg.bins_z        <= 9'd16;
            cfg_reg.channels_used <= 2'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/hbp_index.sv =====
// Index pipeline: quantizes the channels, forms the combined bin index and
// issues the table access in order with table writes. Depends on hbp_pkg.
`timescale 1ns / 1ps

module hbp_index (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  hbp_pkg::item_t     item,
    input  hbp_pkg::cfg_t      cfg,
    output hbp_pkg::mem_req_t  req,
    output hbp_pkg::look_tag_t tag
);
    import hbp_pkg::*;

    // stage 1: captured beat
    logic        v1_reg;
    item_t       it1_reg;

    // stage 2: quantized bins and the row-plane size
    logic        v2_reg;
    logic        mode2_reg;
    logic [11:0] ent2_reg;
    logic [31:0] val2_reg;
    logic [8:0]  qx2_reg;
    logic [8:0]  qy2_reg;
    logic [8:0]  qz2_reg;
    logic [17:0] byx2_reg;

    // stage 3: partial products
    logic        v3_reg;
    logic        mode3_reg;
    logic [11:0] ent3_reg;
    logic [31:0] val3_reg;
    logic [8:0]  qx3_reg;
    logic [17:0] py3_reg;
    logic [26:0] pz3_reg;

    look_tag_t   tag_reg;
    look_tag_t   tag_next;

    logic [16:0] prod_x;
    logic [16:0] prod_y;
    logic [16:0] prod_z;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] went;
    logic        oor;
    logic        wr_ok;
    logic        lookup;

    assign prod_x = 17'(it1_reg.chan_first)  * 17'(cfg.bins_x);
    assign prod_y = 17'(it1_reg.chan_second) * 17'(cfg.bins_y);
    assign prod_z = 17'(it1_reg.chan_third)  * 17'(cfg.bins_z);

    always_comb begin
        case (cfg.channels_used)
            CH_THREE: idx = IDX_W'(pz3_reg) + IDX_W'(py3_reg) + IDX_W'(qx3_reg);
            CH_TWO:   idx = IDX_W'(py3_reg) + IDX_W'(qx3_reg);
            default:  idx = IDX_W'(qx3_reg);
        endcase
    end

    assign oor    = (idx >= IDX_W'(TABLE_DEPTH));
    assign went   = IDX_W'(ent3_reg);
    assign wr_ok  = (went < IDX_W'(TABLE_DEPTH));
    assign lookup = v3_reg && (mode3_reg == MODE_LOOKUP);

    always_comb begin
        req.wr_en = v3_reg && (mode3_reg == MODE_WRITE) && wr_ok;
        req.rd_en = lookup && !oor;
        req.addr  = (mode3_reg == MODE_LOOKUP) ? idx[ADDR_W-1:0] : went[ADDR_W-1:0];
        req.wdata = val3_reg;

        tag_next.valid = lookup;
        tag_next.oor   = oor;
        tag_next.bin   = oor ? '0 : idx[BIN_W-1:0];
    end

    assign tag = tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            tag_reg.valid <= 1'b0;
        end else begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            tag_reg       <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        it1_reg   <= item;

        mode2_reg <= it1_reg.mode;
        ent2_reg  <= it1_reg.entry_index;
        val2_reg  <= it1_reg.entry_value;
        qx2_reg   <= prod_x[16:8];
        qy2_reg   <= prod_y[16:8];
        qz2_reg   <= prod_z[16:8];
        byx2_reg  <= 18'(cfg.bins_y) * 18'(cfg.bins_x);

        mode3_reg <= mode2_reg;
        ent3_reg  <= ent2_reg;
        val3_reg  <= val2_reg;
        qx3_reg   <= qx2_reg;
        py3_reg   <= 18'(qy2_reg) * 18'(cfg.bins_x);
        pz3_reg   <= 27'(qz2_reg) * 27'(byx2_reg);
    end

endmodule

// ===== src/hbp_table.sv =====
// Probability table: single-port synchronous RAM, one write or one read per
// cycle, read data registered. Depends on hbp_pkg for depth and mem_req_t.
`timescale 1ns / 1ps

module hbp_table (
    input  logic                        aclk,
    input  hbp_pkg::mem_req_t           req,
    output logic [hbp_pkg::PROB_W-1:0]  rdata
);
    import hbp_pkg::*;

    logic [PROB_W-1:0] mem_reg [TABLE_DEPTH];
    logic [PROB_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem_reg[req.addr];
        end
    end

endmodule

// ===== src/hbp_out_fifo.sv =====
// Result queue between the table read and the master stream port.
// Depends on hbp_pkg for depth constants and result_t.
`timescale 1ns / 1ps

module hbp_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  hbp_pkg::result_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output hbp_pkg::result_t rd_data
);
    import hbp_pkg::*;

    result_t           buf_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  wptr_next;
    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W-1:0]  rptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              pop;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = buf_reg[rptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wptr_next = wr_en ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = pop   ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = CNT_W'(cnt_reg + CNT_W'(wr_en) - CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Upstream credit keeps the queue from overflowing
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/histogram_backprojection_core.sv =====
// Top level of the histogram back-projection core.
// Depends on hbp_pkg, hbp_regs, hbp_index, hbp_table and hbp_out_fifo.
`timescale 1ns / 1ps

// One beat is taken every clock cycle while s_axis_tready is high, table
// writes and pixel lookups mixed freely; a lookup's result reaches the master
// side through the index stages, the table read and the result queue. Writes
// and lookups reach the single table port in arrival order, so a lookup
// always sees every earlier write. Up to eight lookups may be outstanding;
// s_axis_tready drops only when eight results are queued or in flight while
// the sink holds m_axis_tready low. The table is not cleared at reset: fill
// every entry a lookup can reach before looking it up. Write configuration
// only while no beat is in flight.
module histogram_backprojection_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] entry_index, [43:12] entry_value, [51:44] chan_first,
    // [59:52] chan_second, [67:60] chan_third, [71:68] zero
    input  logic [71:0] s_axis_tdata,
    // [0] mode
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] probability, [43:32] bin_index, [47:44] zero
    output logic [47:0] m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]  m_axis_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hbp_pkg::*;

    cfg_t              cfg;
    item_t             item;
    mem_req_t          req;
    look_tag_t         tag;
    result_t           res_in;
    result_t           res_out;
    logic [PROB_W-1:0] rdata;
    logic              s_acc;
    logic              m_acc;
    logic [CNT_W-1:0]  credit_reg;
    logic [CNT_W-1:0]  credit_next;

    assign item.mode        = s_axis_tuser[0];
    assign item.entry_index = s_axis_tdata[11:0];
    assign item.entry_value = s_axis_tdata[43:12];
    assign item.chan_first  = s_axis_tdata[51:44];
    assign item.chan_second = s_axis_tdata[59:52];
    assign item.chan_third  = s_axis_tdata[67:60];

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Count lookups accepted but not yet delivered
    assign s_axis_tready = (credit_reg < CNT_W'(FIFO_DEPTH));
    assign credit_next   = CNT_W'(credit_reg
                                  + CNT_W'(s_acc && (item.mode == MODE_LOOKUP))
                                  - CNT_W'(m_acc));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    hbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbp_index u_index (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_acc),
        .item     (item),
        .cfg      (cfg),
        .req      (req),
        .tag      (tag)
    );

    hbp_table u_table (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    // Out of range lookups skip the read and report zero
    assign res_in.oor  = tag.oor;
    assign res_in.bin  = tag.bin;
    assign res_in.prob = tag.oor ? '0 : rdata;

    hbp_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (tag.valid),
        .wr_data  (res_in),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (res_out)
    );

    assign m_axis_tdata = {4'd0, res_out.bin, res_out.prob};
    assign m_axis_tuser = res_out.oor;

endmodule

// ===== src/hbp_checker.sv =====
// Port-level checks for the histogram back-projection core, bound to the
// top level. Depends only on the top level's port names.
`timescale 1ns / 1ps

module hbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Stalled result beat stays valid
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Stalled result beat keeps its payload
    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Out of range result carries zero probability and index
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[43:0] == 44'd0))
        else $error("out of range result with nonzero data");

    // Input backpressure only while results are waiting
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind histogram_backprojection_core hbp_checker u_hbp_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for histogram_backprojection_core: table writes and
// pixel lookups on the stream ports, bin settings over APB. Depends on hbp_pkg.
`timescale 1ns / 1ps

module tb_top;
    import hbp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 21;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [11:0] entry_index, [43:12] entry_value, [51:44] chan_first,
    // [59:52] chan_second, [67:60] chan_third, [71:68] zero
    logic [71:0] s_axis_tdata  = '0;
    // [0] mode
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] probability, [43:32] bin_index, [47:44] zero
    logic [47:0] m_axis_tdata;
    // [0] out_of_range
    logic [0:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: shadow of the probability table and of the bin settings
    logic [31:0] shadow_table [TABLE_DEPTH];
    bit          entry_written [TABLE_DEPTH];
    cfg_t        bin_cfg;
    result_t     pending_results [$];

    bit sender_pauses = 1'b1;
    bit sink_pauses   = 1'b1;
    int error_count   = 0;
    int stall_cycles  = 0;
    int n_writes      = 0;
    int n_lookups     = 0;
    int n_out_range   = 0;
    int n_settings    = 0;

    histogram_backprojection_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_axis_tready <= !sink_pauses || ($urandom_range(99) >= IDLE_PCT);
    end

    // Combined histogram index of a pixel under the current bin settings
    function automatic longint combined_bin(input item_t it);
        longint qx;
        longint qy;
        longint qz;
        qx = (longint'(it.chan_first)  * longint'(bin_cfg.bins_x)) >> 8;
        qy = (longint'(it.chan_second) * longint'(bin_cfg.bins_y)) >> 8;
        qz = (longint'(it.chan_third)  * longint'(bin_cfg.bins_z)) >> 8;
        case (bin_cfg.channels_used)
            CH_THREE: return qz * bin_cfg.bins_y * bin_cfg.bins_x + qy * bin_cfg.bins_x + qx;
            CH_TWO:   return qy * bin_cfg.bins_x + qx;
            default:  return qx;
        endcase
    endfunction

    function automatic result_t backproject_pixel(input item_t it);
        longint  idx;
        result_t r;
        idx = combined_bin(it);
        if (idx < TABLE_DEPTH) begin
            r.prob = shadow_table[idx];
            r.bin  = BIN_W'(idx);
            r.oor  = 1'b0;
        end else begin
            r.prob = '0;
            r.bin  = '0;
            r.oor  = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [8:0] pick_bins();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(511, 257));
            4, 5, 6: return 9'($urandom_range(16, 1));
            default: return 9'($urandom_range(256, 1));
        endcase
    endfunction

    // Checker: compare each result beat with the oldest pending lookup
    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no lookup pending: tdata=%h tuser=%h",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.oor) n_out_range++;
                if (m_axis_tdata[31:0] !== want.prob) begin
                    $error("probability: expected %h, got %h", want.prob, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[43:32] !== want.bin) begin
                    $error("bin_index: expected %0d, got %0d", want.bin, m_axis_tdata[43:32]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.oor) begin
                    $error("out_of_range: expected %0d, got %0d", want.oor, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Present one beat, hold it until accepted, then update the predictor
    task automatic send_beat(input item_t it);
        if (sender_pauses) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.chan_third, it.chan_second, it.chan_first,
                          it.entry_value, it.entry_index};
        s_axis_tuser  <= it.mode;
        do @(posedge aclk); while (!s_axis_tready);
        if (it.mode == MODE_WRITE) begin
            shadow_table[it.entry_index]  = it.entry_value;
            entry_written[it.entry_index] = 1'b1;
            n_writes++;
        end else begin
            pending_results.push_back(backproject_pixel(it));
            n_lookups++;
        end
        @(negedge aclk);
    endtask

    task automatic send_write(input logic [11:0] idx, input logic [31:0] value);
        item_t it;
        it.mode        = MODE_WRITE;
        it.entry_index = idx;
        it.entry_value = value;
        it.chan_first  = 8'($urandom);
        it.chan_second = 8'($urandom);
        it.chan_third  = 8'($urandom);
        send_beat(it);
    endtask

    // Look up a pixel; fill its table entry first if it was never written
    task automatic send_pixel(input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
        item_t  it;
        longint idx;
        it.mode        = MODE_LOOKUP;
        it.entry_index = 12'($urandom);
        it.entry_value = $urandom;
        it.chan_first  = c1;
        it.chan_second = c2;
        it.chan_third  = c3;
        idx = combined_bin(it);
        if (idx < TABLE_DEPTH && !entry_written[idx])
            send_write(12'(idx), $urandom);
        send_beat(it);
    endtask

    task automatic read_reg(input logic [1:0] id, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {id, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] id, input logic [31:0] value);
        logic [31:0] got;
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {id, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (id)
            REG_BINS_X: bin_cfg.bins_x = value[8:0];
            REG_BINS_Y: bin_cfg.bins_y = value[8:0];
            REG_BINS_Z: bin_cfg.bins_z = value[8:0];
            default:    bin_cfg.channels_used = value[1:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        want = (id == REG_CHANNELS_USED) ? {30'b0, value[1:0]} : {23'b0, value[8:0]};
        read_reg(id, got);
        if (got !== want) begin
            $error("register %0d readback: expected %0d, got %0d", id, want, got);
            error_count++;
        end
    endtask

    // Drain outstanding lookups, let trailing writes settle, then reprogram
    task automatic configure(input logic [8:0] bx, input logic [8:0] by, input logic [8:0] bz,
                             input logic [1:0] chans);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        set_reg(REG_BINS_X, {$urandom_range(1) ? 23'h7fffff : 23'h0, bx});
        set_reg(REG_BINS_Y, {23'b0, by});
        set_reg(REG_BINS_Z, {23'b0, bz});
        set_reg(REG_CHANNELS_USED, {30'b0, chans});
        n_settings++;
    endtask

    task automatic test_register_reset();
        logic [31:0] got;
        read_reg(REG_BINS_X, got);
        if (got !== 32'd16) begin $error("bins_x reset: expected 16, got %0d", got); error_count++; end
        read_reg(REG_BINS_Y, got);
        if (got !== 32'd16) begin $error("bins_y reset: expected 16, got %0d", got); error_count++; end
        read_reg(REG_BINS_Z, got);
        if (got !== 32'd16) begin $error("bins_z reset: expected 16, got %0d", got); error_count++; end
        read_reg(REG_CHANNELS_USED, got);
        if (got !== 32'd3) begin
            $error("channels_used reset: expected 3, got %0d", got);
            error_count++;
        end
    endtask

    task automatic test_directed();
        // Reset settings: 16 bins per channel, three channels
        send_write(12'd0, 32'h0000_0000);
        send_write(12'hfff, 32'hffff_ffff);
        send_write(12'haaa, 32'haaaa_aaaa);
        send_write(12'h555, 32'h5555_5555);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'haa, 8'haa, 8'haa);
        send_write(12'd0, 32'h1234_5678);
        send_pixel(8'd15, 8'd0, 8'd0);
        // One channel, full 256 bins: index equals the first channel
        configure(9'd256, 9'd1, 9'd1, 2'd1);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        // Two channels, 256x256: top corner falls off the table
        configure(9'd256, 9'd256, 9'd1, CH_TWO);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd15, 8'd15, 8'd200);
        // Zero channel count acts as one channel; zero bins map to bin 0
        configure(9'd0, 9'd511, 9'd0, 2'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        // Bin counts above 256
        configure(9'd511, 9'd511, 9'd511, CH_THREE);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        // Single bin everywhere
        configure(9'd1, 9'd1, 9'd1, CH_THREE);
        send_pixel(8'd255, 8'd255, 8'd255);
    endtask

    task automatic run_random_items(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 25)
                send_write(12'($urandom), $urandom);
            else if (r < 32)
                send_pixel($urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
                           $urandom_range(1) ? 8'hff : 8'h00);
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            configure(pick_bins(), pick_bins(), pick_bins(), 2'($urandom_range(3)));
            run_random_items(85);
        end
    endtask

    task automatic test_full_rate();
        configure(9'($urandom_range(16, 1)), 9'($urandom_range(16, 1)),
                  9'($urandom_range(16, 1)), CH_THREE);
        sender_pauses = 1'b0;
        sink_pauses   = 1'b0;
        run_random_items(120);
        sender_pauses = 1'b1;
        sink_pauses   = 1'b1;
    endtask

    initial begin
        bin_cfg = '{bins_x: 9'd16, bins_y: 9'd16, bins_z: 9'd16, channels_used: 2'd3};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_reset();
        test_directed();
        test_random_settings();
        test_full_rate();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Sent %0d table writes and %0d pixel lookups (%0d out of range)",
                 n_writes, n_lookups, n_out_range);
        $display("across %0d bin settings, with random and full-rate flow control",
                 n_settings + 1);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
